@@ hw/rtl/imu_tha_pkg.sv @@
// Shared constants, command struct and arctangent table for the IMU angle block.
`timescale 1ns / 1ps

package imu_tha_pkg;

  // Vectoring iterations of the atan2 unit, capped at the table length.
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_TAB_LEN = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;
  localparam int CNT_W        = $clog2(ATAN_TAB_LEN);

  localparam int IN_W      = 16;   // raw sensor reading
  localparam int SCALE_W   = 24;   // gyro step scale register
  localparam int ACC_W     = 40;   // angle accumulator
  localparam int INC_W     = 32;   // product after the 2^-8 shift
  localparam int CW        = 28;   // CORDIC x/y datapath
  localparam int AW        = 26;   // CORDIC angle, 2^-16 degree
  localparam int ANG_W     = 18;   // rounded angle, 2^-8 degree, with headroom
  localparam int OUT_ANG_W = 17;   // angle fields on the output

  localparam int IN_DATA_W    = 9 * IN_W;
  localparam int OUT_FIELDS_W = 3 * ACC_W + 3 * OUT_ANG_W + 3 * IN_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(23488);

  // Angles in units of 2^-8 degree.
  localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(23040);
  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(46080);
  localparam logic signed [ANG_W-1:0] DEG270 = ANG_W'(69120);
  localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(92160);

  // Half turn in CORDIC angle units (2^-16 degree).
  localparam logic signed [AW-1:0] Z_HALF_TURN = AW'(46080 * 256);
  localparam logic signed [AW-1:0] Z_ROUND     = AW'(128);

  typedef enum logic [1:0] {
    RUN_TILT_X  = 2'd0,
    RUN_TILT_Y  = 2'd1,
    RUN_HEADING = 2'd2
  } run_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic             load_in;
    logic             mul_en;
    axis_e            mul_sel;
    logic             acc_en;
    axis_e            acc_sel;
    logic             c_init;
    logic             c_iter;
    logic             c_done;
    run_e             run;
    logic [CNT_W-1:0] iter;
    logic             load_out;
  } cmd_t;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic signed [AW-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0:    v = AW'(2949120);
      5'd1:    v = AW'(1740967);
      5'd2:    v = AW'(919879);
      5'd3:    v = AW'(466945);
      5'd4:    v = AW'(234379);
      5'd5:    v = AW'(117304);
      5'd6:    v = AW'(58666);
      5'd7:    v = AW'(29335);
      5'd8:    v = AW'(14668);
      5'd9:    v = AW'(7334);
      5'd10:   v = AW'(3667);
      5'd11:   v = AW'(1833);
      5'd12:   v = AW'(917);
      5'd13:   v = AW'(458);
      5'd14:   v = AW'(229);
      5'd15:   v = AW'(115);
      5'd16:   v = AW'(57);
      5'd17:   v = AW'(29);
      5'd18:   v = AW'(14);
      5'd19:   v = AW'(7);
      5'd20:   v = AW'(4);
      5'd21:   v = AW'(2);
      5'd22:   v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/imu_tha_ctrl.sv @@
// Sequencer for the IMU angle block: gyro integration, three atan2 runs, output hand-off.
`timescale 1ns / 1ps

module imu_tha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output imu_tha_pkg::cmd_t  cmd_o
);
  import imu_tha_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_GYRO  = 6'b000010,
    ST_CINIT = 6'b000100,
    ST_CITER = 6'b001000,
    ST_CDONE = 6'b010000,
    ST_PUSH  = 6'b100000
  } state_e;

  // Three multiplies, the last accumulate lands one step later.
  localparam logic [CNT_W-1:0] GYRO_LAST = CNT_W'(3);
  localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_ITERS - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  run_e             run_q, run_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.run   = run_q;
    cmd_o.iter  = cnt_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = ST_GYRO;
        end
      end
      ST_GYRO: begin
        if (cnt_q != GYRO_LAST) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = axis_e'(cnt_q[1:0]);
        end
        if (cnt_q != '0) begin
          cmd_o.acc_en  = 1'b1;
          cmd_o.acc_sel = axis_e'(cnt_q[1:0] - 2'd1);
        end
        if (cnt_q == GYRO_LAST) begin
          cnt_d   = '0;
          run_d   = RUN_TILT_X;
          state_d = ST_CINIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_CINIT: begin
        cmd_o.c_init = 1'b1;
        cnt_d        = '0;
        state_d      = ST_CITER;
      end
      ST_CITER: begin
        cmd_o.c_iter = 1'b1;
        if (cnt_q == ITER_LAST) begin
          state_d = ST_CDONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_CDONE: begin
        cmd_o.c_done = 1'b1;
        if (run_q == RUN_HEADING) begin
          state_d = ST_PUSH;
        end else begin
          run_d   = (run_q == RUN_TILT_X) ? RUN_TILT_Y : RUN_HEADING;
          state_d = ST_CINIT;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      run_q       <= RUN_TILT_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/imu_tha_dp.sv @@
// Datapath for the IMU angle block: shared gyro multiplier, accumulators, CORDIC atan2 unit.
`timescale 1ns / 1ps

module imu_tha_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  imu_tha_pkg::cmd_t                      cmd_i,
  input  logic                                   cfg_we_i,
  input  logic [imu_tha_pkg::SCALE_W-1:0]        cfg_data_i,
  input  logic [imu_tha_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic [imu_tha_pkg::OUT_FIELDS_W-1:0]   out_data_o
);
  import imu_tha_pkg::*;

  logic [SCALE_W-1:0]      scale_q;
  logic [IN_DATA_W-1:0]    in_q;
  logic [OUT_FIELDS_W-1:0] out_q;

  logic signed [IN_W-1:0] gx, gy, gz, ax, ay, az, mx, my;
  assign gx = in_q[0*IN_W +: IN_W];
  assign gy = in_q[1*IN_W +: IN_W];
  assign gz = in_q[2*IN_W +: IN_W];
  assign ax = in_q[3*IN_W +: IN_W];
  assign ay = in_q[4*IN_W +: IN_W];
  assign az = in_q[5*IN_W +: IN_W];
  assign mx = in_q[6*IN_W +: IN_W];
  assign my = in_q[7*IN_W +: IN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  // ---- gyro integration: one multiplier, one axis per cycle ----
  logic signed [IN_W-1:0]  rate_sel;
  logic signed [ACC_W:0]   prod_full;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [INC_W-1:0] inc;
  logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_z_q, acc_cur, acc_new;
  logic signed [ACC_W:0]   acc_sum;

  always_comb begin
    case (cmd_i.mul_sel)
      AXIS_X:  rate_sel = gx;
      AXIS_Y:  rate_sel = gy;
      default: rate_sel = gz;
    endcase
  end

  assign prod_full = rate_sel * $signed({1'b0, scale_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[ACC_W-1:0];
    end
  end

  // Floor shift by 8 is the upper slice of the product.
  assign inc = prod_q[ACC_W-1:ACC_W-INC_W];

  always_comb begin
    case (cmd_i.acc_sel)
      AXIS_X:  acc_cur = acc_x_q;
      AXIS_Y:  acc_cur = acc_y_q;
      default: acc_cur = acc_z_q;
    endcase
    acc_sum = {acc_cur[ACC_W-1], acc_cur} + (ACC_W+1)'(inc);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      // Saturate toward the sign of the true sum.
      acc_new = {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}};
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
    end else if (cmd_i.acc_en) begin
      case (cmd_i.acc_sel)
        AXIS_X:  acc_x_q <= acc_new;
        AXIS_Y:  acc_y_q <= acc_new;
        default: acc_z_q <= acc_new;
      endcase
    end
  end

  // ---- CORDIC atan2 in vectoring mode ----
  logic signed [IN_W-1:0]      op_y, op_x;
  logic signed [CW-1:0]        ys, xs, cx_q, cy_q, shx, shy;
  logic signed [AW-1:0]        cz_q, at, zrnd;
  logic                        zero_q, xneg_q;
  logic signed [ANG_W-1:0]     ang_r, ang, tilt_a, ty_full, hd_full;
  logic [OUT_ANG_W-1:0]        tx_q, ty_q, hd_q;

  always_comb begin
    case (cmd_i.run)
      RUN_TILT_X: begin
        op_y = ay;
        op_x = az;
      end
      RUN_TILT_Y: begin
        op_y = az;
        op_x = ax;
      end
      default: begin
        op_y = my;
        op_x = mx;
      end
    endcase
  end

  assign ys  = {{(CW-IN_W-8){op_y[IN_W-1]}}, op_y, 8'h00};
  assign xs  = {{(CW-IN_W-8){op_x[IN_W-1]}}, op_x, 8'h00};
  assign shx = cx_q >>> cmd_i.iter;
  assign shy = cy_q >>> cmd_i.iter;
  assign at  = atan_lut(cmd_i.iter);

  always_ff @(posedge clk_i) begin
    if (cmd_i.c_init) begin
      zero_q <= (op_y == '0);
      xneg_q <= op_x[IN_W-1];
      if (op_x[IN_W-1]) begin
        // Rotate by a half turn so x starts non-negative.
        cx_q <= -xs;
        cy_q <= -ys;
        cz_q <= op_y[IN_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
      end else begin
        cx_q <= xs;
        cy_q <= ys;
        cz_q <= '0;
      end
    end else if (cmd_i.c_iter) begin
      if (!cy_q[CW-1]) begin
        cx_q <= cx_q + shy;
        cy_q <= cy_q - shx;
        cz_q <= cz_q + at;
      end else begin
        cx_q <= cx_q - shy;
        cy_q <= cy_q + shx;
        cz_q <= cz_q - at;
      end
    end
  end

  always_comb begin
    zrnd  = cz_q + Z_ROUND;
    ang_r = zrnd[AW-1:AW-ANG_W];
    if (zero_q) begin
      ang = xneg_q ? DEG180 : '0;
    end else if (ang_r > DEG180) begin
      ang = DEG180;
    end else if (ang_r < -DEG180) begin
      ang = -DEG180;
    end else begin
      ang = ang_r;
    end
    tilt_a  = ang + DEG180;
    ty_full = (tilt_a > DEG90) ? (tilt_a - DEG270) : (tilt_a + DEG90);
    hd_full = ang[ANG_W-1] ? (ang + DEG360) : ang;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.c_done) begin
      case (cmd_i.run)
        RUN_TILT_X: tx_q <= ang[OUT_ANG_W-1:0];
        RUN_TILT_Y: ty_q <= ty_full[OUT_ANG_W-1:0];
        default:    hd_q <= hd_full[OUT_ANG_W-1:0];
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {in_q[IN_DATA_W-1:6*IN_W], hd_q, ty_q, tx_q, acc_z_q, acc_y_q, acc_x_q};
    end
  end

  assign out_data_o = out_q;

endmodule

@@ hw/rtl/imu_tilt_heading_angles.sv @@
// Top level of the IMU angle block: gyro integration, accelerometer tilt and compass heading.
`timescale 1ns / 1ps

// One nine-axis sample goes in per transfer and one result comes out for it.
// Each gyro rate is multiplied by gyro_step_scale, shifted down to 2^-16
// degree and added to a saturating 40-bit angle accumulator per axis. Tilt X
// is atan2(accel_y, accel_z), tilt Y is atan2(accel_z, accel_x) moved by 180
// degrees and folded by the 90/270 rule, and heading is atan2(mag_y, mag_x)
// folded into 0..360 degrees; all three are in 2^-8 degree. The magnetometer
// readings pass through. One item is worked at a time: one shared CORDIC
// vectoring unit runs the three atan2s in turn after the shared gyro
// multiplier has done its three axes. A finished result is held in an
// output register, so the next sample is taken while it still waits; a new
// result waits until that register is free. The scale register takes a
// write in any cycle and must only be written while no sample is in flight.

module imu_tilt_heading_angles (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // gyro step scale register write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [imu_tha_pkg::SCALE_W-1:0]      cfg_data_i,
  // sample in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // gyro_rate_x, gyro_rate_y, gyro_rate_z, accel_x, accel_y, accel_z,
  // mag_x, mag_y, mag_z (16 bits each, from bit 0 up)
  input  logic [imu_tha_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // result out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // gyro_angle_x, gyro_angle_y, gyro_angle_z (40 bits each), tilt_angle_x,
  // tilt_angle_y, heading (17 bits each), mag_out_x, mag_out_y, mag_out_z
  // (16 bits each), zero fill to 224 bits
  output logic [imu_tha_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import imu_tha_pkg::*;

  cmd_t                    cmd;
  logic [OUT_FIELDS_W-1:0] out_fields;

  // Scale register takes every transfer.
  assign cfg_ready_o = 1'b1;

  imu_tha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  imu_tha_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (out_fields)
  );

  // Pad the result up to whole bytes.
  assign m_axis_tdata = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_fields};

`ifndef NO_ASSERTIONS
  logic signed [OUT_ANG_W-1:0] tx_chk, ty_chk;
  logic [OUT_ANG_W-1:0]        hd_chk;

  assign tx_chk = m_axis_tdata[3*ACC_W +: OUT_ANG_W];
  assign ty_chk = m_axis_tdata[3*ACC_W+OUT_ANG_W +: OUT_ANG_W];
  assign hd_chk = m_axis_tdata[3*ACC_W+2*OUT_ANG_W +: OUT_ANG_W];

  // One sample in flight: an accepted transfer closes the input at once.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  // Heading stays folded into 0..360 degrees.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (hd_chk <= OUT_ANG_W'(92160)))
    else $error("heading out of range");

  // Both tilt angles stay within a half turn.
  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((tx_chk <= 17'sd46080) && (tx_chk >= -17'sd46080) &&
                       (ty_chk <= 17'sd46080) && (ty_chk >= -17'sd46080)))
    else $error("tilt angle out of range");
`endif

endmodule
